>>> hdl/kecd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecd_pkg: shared types and constants for the key event decoder
// Key kind codes, the keymap rows and the key number to grid position decode.
// ----------------------------------------------------------------------------
package kecd_pkg;

  localparam int unsigned GRID_COLS = 14;

  // Key kind codes carried on the result channel.
  localparam logic [3:0] KIND_TEXT  = 4'd0;
  localparam logic [3:0] KIND_TAB   = 4'd1;
  localparam logic [3:0] KIND_ENTER = 4'd2;
  localparam logic [3:0] KIND_DEL   = 4'd3;
  localparam logic [3:0] KIND_SPACE = 4'd4;
  localparam logic [3:0] KIND_SHIFT = 4'd5;
  localparam logic [3:0] KIND_CAPS  = 4'd6;
  localparam logic [3:0] KIND_CTRL  = 4'd7;
  localparam logic [3:0] KIND_OPT   = 4'd8;
  localparam logic [3:0] KIND_ALT   = 4'd9;

  // Modifier word bit positions.
  localparam int unsigned MOD_SHIFT = 0;
  localparam int unsigned MOD_CTRL  = 1;
  localparam int unsigned MOD_ALT   = 2;
  localparam int unsigned MOD_FN    = 3;

  localparam logic [7:0] EVT_PRESS = 8'h80;

  // Keymap rows; the leftmost character is column 0.
  localparam logic [GRID_COLS*8-1:0] PLAIN_ROW0 = {8'h60, "1234567890-= "};
  localparam logic [GRID_COLS*8-1:0] PLAIN_ROW1 = " qwertyuiop[]\\";
  localparam logic [GRID_COLS*8-1:0] PLAIN_ROW2 = "  asdfghjkl;' ";
  localparam logic [GRID_COLS*8-1:0] PLAIN_ROW3 = "   zxcvbnm,./ ";
  localparam logic [GRID_COLS*8-1:0] SHIFT_ROW0 = "~!@#$%^&*()_+ ";
  localparam logic [GRID_COLS*8-1:0] SHIFT_ROW1 = " QWERTYUIOP{}|";
  localparam logic [GRID_COLS*8-1:0] SHIFT_ROW2 = "  ASDFGHJKL:\" ";
  localparam logic [GRID_COLS*8-1:0] SHIFT_ROW3 = "   ZXCVBNM<>? ";

  typedef struct packed {
    logic       on_grid;
    logic [1:0] row;
    logic [3:0] col;
  } grid_pos_t;

  // Map a zero-based key index onto the 4 x 14 grid. The tens digit comes
  // from a compare ladder, so no divider is needed.
  function automatic grid_pos_t key_position(input logic [6:0] idx);
    grid_pos_t  pos;
    logic [2:0] tens;
    logic [6:0] rem_w;
    logic [3:0] rem;
    tens = (idx >= 7'd70) ? 3'd7 :
           (idx >= 7'd60) ? 3'd6 :
           (idx >= 7'd50) ? 3'd5 :
           (idx >= 7'd40) ? 3'd4 :
           (idx >= 7'd30) ? 3'd3 :
           (idx >= 7'd20) ? 3'd2 :
           (idx >= 7'd10) ? 3'd1 : 3'd0;
    rem_w       = idx - 7'({4'd0, tens} * 7'd10);
    rem         = rem_w[3:0];
    pos.on_grid = (tens != 3'd7);
    pos.row     = rem[1:0];
    pos.col     = {tens, 1'b0} + {3'd0, (rem > 4'd3)};
    return pos;
  endfunction

  function automatic logic [3:0] key_kind_of(input logic [1:0] row, input logic [3:0] col);
    logic [3:0] kind;
    kind = KIND_TEXT;
    case (row)
      2'd0: begin
        if (col == 4'd13) kind = KIND_DEL;
      end
      2'd1: begin
        if (col == 4'd0) kind = KIND_TAB;
      end
      2'd2: begin
        if (col == 4'd0) kind = KIND_SHIFT;
        else if (col == 4'd1) kind = KIND_CAPS;
        else if (col == 4'd13) kind = KIND_ENTER;
      end
      2'd3: begin
        if (col == 4'd0) kind = KIND_CTRL;
        else if (col == 4'd1) kind = KIND_OPT;
        else if (col == 4'd2) kind = KIND_ALT;
        else if (col == 4'd13) kind = KIND_SPACE;
      end
      default: kind = KIND_TEXT;
    endcase
    return kind;
  endfunction

  function automatic logic [6:0] keymap_char(input logic shifted, input logic [1:0] row,
                                             input logic [3:0] col);
    logic [GRID_COLS*8-1:0] line;
    logic [3:0]             slot;
    case ({shifted, row})
      3'b000:  line = PLAIN_ROW0;
      3'b001:  line = PLAIN_ROW1;
      3'b010:  line = PLAIN_ROW2;
      3'b011:  line = PLAIN_ROW3;
      3'b100:  line = SHIFT_ROW0;
      3'b101:  line = SHIFT_ROW1;
      3'b110:  line = SHIFT_ROW2;
      default: line = SHIFT_ROW3;
    endcase
    slot = 4'(GRID_COLS - 1) - col;
    return line[{slot, 3'b000} +: 7];
  endfunction

endpackage

>>> hdl/key_event_to_char_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_to_char_decoder: key controller event to character decoder
// Decodes raw key events into key kind, modifier levels and ASCII text.
// ----------------------------------------------------------------------------
// Path: an accepted press event lands in the input register, then in the result
// register, from which it shows on the result port.
// Throughput: one event per cycle unless the result port stalls; the input register drains whenever the
// result register is free or the event produces no result.
// Reset: synchronous, active low; it empties both registers and clears the
// shift, ctrl, alt and opt levels and the caps lock toggle.
module key_event_to_char_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_event_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_key_kind,
  output logic [3:0] out_modifier_bits,
  output logic [6:0] out_char_code
);

  // Input register holding one accepted beat.
  logic       evt_valid_r;
  logic [7:0] evt_r;

  // Modifier state.
  logic shift_r, ctrl_r, alt_r, opt_r, caps_r;
  logic shift_nxt, ctrl_nxt, alt_nxt, opt_nxt, caps_nxt;

  // Result register.
  logic       res_valid_r;
  logic [3:0] res_kind_r, res_kind_nxt;
  logic [3:0] res_mod_r, res_mod_nxt;
  logic [6:0] res_char_r, res_char_nxt;

  kecd_pkg::grid_pos_t pos;
  logic [6:0] key_idx;
  logic [3:0] kind;
  logic       pressed;
  logic       live;      // Nonzero key number that lands on the grid.
  logic       emits;     // Event produces a result beat.
  logic       res_free;  // Result register can take a new beat this cycle.
  logic       evt_go;    // Input register hands its event on this cycle.
  logic [6:0] plain_ch;
  logic       upper;

  // Decode of the event in the input register.
  always_comb begin
    pressed = evt_r[7];
    key_idx = evt_r[6:0] - 7'd1;
    pos     = kecd_pkg::key_position(key_idx);
    live    = (evt_r[6:0] != 7'd0) && pos.on_grid;
    kind    = kecd_pkg::key_kind_of(pos.row, pos.col);
    emits   = live && pressed;
  end

  assign res_free = !res_valid_r || out_ready;
  assign evt_go   = evt_valid_r && (!emits || res_free);
  assign in_ready = !evt_valid_r || evt_go;

  // Modifier levels follow press and release; caps lock toggles on a press.
  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    opt_nxt   = opt_r;
    caps_nxt  = caps_r;
    if (live) begin
      if (kind == kecd_pkg::KIND_SHIFT) shift_nxt = pressed;
      if (kind == kecd_pkg::KIND_CTRL)  ctrl_nxt  = pressed;
      if (kind == kecd_pkg::KIND_ALT)   alt_nxt   = pressed;
      if (kind == kecd_pkg::KIND_OPT)   opt_nxt   = pressed;
      if (kind == kecd_pkg::KIND_CAPS && pressed) caps_nxt = !caps_r;
    end
  end

  // Result fields. The modifier word reflects the state after this event.
  // Letters pick the shifted keymap row with shift xor caps lock, other text keys
  // with shift alone.
  always_comb begin
    plain_ch     = kecd_pkg::keymap_char(1'b0, pos.row, pos.col);
    upper        = (plain_ch inside {[7'h61:7'h7A]}) ? (shift_nxt ^ caps_nxt) : shift_nxt;
    res_kind_nxt = kind;
    res_mod_nxt  = '0;
    res_mod_nxt[kecd_pkg::MOD_SHIFT] = shift_nxt;
    res_mod_nxt[kecd_pkg::MOD_CTRL]  = ctrl_nxt;
    res_mod_nxt[kecd_pkg::MOD_ALT]   = alt_nxt;
    res_mod_nxt[kecd_pkg::MOD_FN]    = opt_nxt;
    res_char_nxt = '0;
    if (kind == kecd_pkg::KIND_TEXT) begin
      res_char_nxt = upper ? kecd_pkg::keymap_char(1'b1, pos.row, pos.col) : plain_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
    end else if (in_ready) begin
      evt_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt_r <= in_event_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      opt_r   <= 1'b0;
      caps_r  <= 1'b0;
    end else if (evt_go) begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
      opt_r   <= opt_nxt;
      caps_r  <= caps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= evt_go && emits;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_go && emits) begin
      res_kind_r <= res_kind_nxt;
      res_mod_r  <= res_mod_nxt;
      res_char_r <= res_char_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_key_kind      = res_kind_r;
  assign out_modifier_bits = res_mod_r;
  assign out_char_code     = res_char_r;

endmodule

>>> hdl/kecd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecd_checker: port-level checks for the key event decoder
// Watches the result channel for consistency of kind, modifiers and text.
// ----------------------------------------------------------------------------
module kecd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_key_kind,
  input logic [3:0] out_modifier_bits,
  input logic [6:0] out_char_code
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_kind) &&
    $stable(out_modifier_bits) && $stable(out_char_code))
    else $error("result beat changed while stalled");

  // Only text beats carry a character.
  a_char_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_kind != kecd_pkg::KIND_TEXT |-> out_char_code == 7'd0)
    else $error("non-text beat carries a character");

  // A modifier press shows its own level as held.
  a_mod_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_key_kind == kecd_pkg::KIND_SHIFT ||
                  out_key_kind == kecd_pkg::KIND_CTRL ||
                  out_key_kind == kecd_pkg::KIND_ALT ||
                  out_key_kind == kecd_pkg::KIND_OPT) |->
    (out_key_kind != kecd_pkg::KIND_SHIFT || out_modifier_bits[kecd_pkg::MOD_SHIFT]) &&
    (out_key_kind != kecd_pkg::KIND_CTRL  || out_modifier_bits[kecd_pkg::MOD_CTRL]) &&
    (out_key_kind != kecd_pkg::KIND_ALT   || out_modifier_bits[kecd_pkg::MOD_ALT]) &&
    (out_key_kind != kecd_pkg::KIND_OPT   || out_modifier_bits[kecd_pkg::MOD_FN]))
    else $error("modifier press without its level held");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind key_event_to_char_decoder kecd_checker u_kecd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_key_kind      (out_key_kind),
  .out_modifier_bits (out_modifier_bits),
  .out_char_code     (out_char_code)
);
